FILE: design/swtq_pkg.sv
// Shared types and constants for the sorted wake-up timer queue.
package swtq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int TIME_W        = 32;
  localparam int ID_W          = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] wake;
    logic [ID_W-1:0]   id;
  } entry_t;

  // Per-beat command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic pop;
  } ctrl_t;

endpackage

FILE: design/swtq_cell.sv
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
module swtq_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  swtq_pkg::ctrl_t         ctrl,
  input  swtq_pkg::entry_t        new_entry,
  input  logic [swtq_pkg::ID_W-1:0] lookup_id,
  input  swtq_pkg::entry_t        left_ent,
  input  logic                    left_le,
  input  swtq_pkg::entry_t        right_ent,
  output swtq_pkg::entry_t        ent,
  output swtq_pkg::entry_t        ent_next,
  output logic                    le,
  output logic                    hit
);

  logic                        valid;
  logic [swtq_pkg::TIME_W-1:0] wake;
  logic [swtq_pkg::ID_W-1:0]   id;

  assign ent = {valid, wake, id};

  // Entries at or before the new time stay put; FIFO order on ties.
  assign le  = valid && (wake <= new_entry.wake);
  assign hit = valid && (id == lookup_id);

  always_comb begin
    ent_next = ent;
    if (ctrl.ins) begin
      if (le) begin
        ent_next = ent;
      end else if (left_le) begin
        ent_next = new_entry;
      end else begin
        ent_next = left_ent;
      end
    end else if (ctrl.pop) begin
      ent_next = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ent_next.valid;
    end
    wake <= ent_next.wake;
    id   <= ent_next.id;
  end

endmodule

FILE: design/sorted_wakeup_timer_queue.sv
// Top level of the sorted wake-up timer queue: cell row plus result register.
// The result beat is registered and appears in the cycle after the input beat is accepted.
// Throughput: one item per cycle; every cell updates in parallel,
// and a new beat is taken whenever the result register is free or draining.
// Reset clears the cell valid bits (queue empty) and the result valid;
// stored times and ids are left as they are.
module sorted_wakeup_timer_queue #(
  parameter int QUEUE_DEPTH = swtq_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic [swtq_pkg::ID_W-1:0]     process_id,
  input  logic [swtq_pkg::TIME_W-1:0]   wake_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [swtq_pkg::ID_W-1:0]     result_id,
  output logic                          head_valid,
  output logic [swtq_pkg::TIME_W-1:0]   head_time
);

  swtq_pkg::entry_t cell_ent      [QUEUE_DEPTH];
  swtq_pkg::entry_t cell_ent_next [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_le;
  logic [QUEUE_DEPTH-1:0] cell_hit;
  logic [QUEUE_DEPTH-1:0] valid_vec;

  swtq_pkg::ctrl_t  ctrl;
  swtq_pkg::entry_t new_entry;
  swtq_pkg::op_t    op;
  logic             accept;
  logic             full;

  logic [1:0]                  status_next;
  logic [swtq_pkg::ID_W-1:0]   result_id_next;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign op        = swtq_pkg::op_t'(opcode);
  assign full      = cell_ent[QUEUE_DEPTH-1].valid;
  assign new_entry = {1'b1, wake_time, process_id};

  assign ctrl.ins = accept && (op == swtq_pkg::OP_INSERT) && !full;
  assign ctrl.pop = accept && (op == swtq_pkg::OP_POP);

  genvar k;
  generate
    for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      swtq_pkg::entry_t left_ent;
      swtq_pkg::entry_t right_ent;
      logic             left_le;

      if (k == 0) begin : g_head
        assign left_ent = '0;
        assign left_le  = 1'b1;
      end else begin : g_mid
        assign left_ent = cell_ent[k-1];
        assign left_le  = cell_le[k-1];
      end

      if (k == QUEUE_DEPTH-1) begin : g_tail
        assign right_ent = '0;
      end else begin : g_body
        assign right_ent = cell_ent[k+1];
      end

      swtq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .new_entry (new_entry),
        .lookup_id (process_id),
        .left_ent  (left_ent),
        .left_le   (left_le),
        .right_ent (right_ent),
        .ent       (cell_ent[k]),
        .ent_next  (cell_ent_next[k]),
        .le        (cell_le[k]),
        .hit       (cell_hit[k])
      );

      assign valid_vec[k] = cell_ent[k].valid;
    end
  endgenerate

  // Lookup reports the searched id itself, so any match is enough.
  always_comb begin
    status_next    = swtq_pkg::ST_OK;
    result_id_next = '0;
    case (op)
      swtq_pkg::OP_INSERT: begin
        if (full) begin
          status_next = swtq_pkg::ST_FULL;
        end
      end
      swtq_pkg::OP_POP: begin
        if (cell_ent[0].valid) begin
          result_id_next = cell_ent[0].id;
        end else begin
          status_next = swtq_pkg::ST_EMPTY;
        end
      end
      swtq_pkg::OP_LOOKUP: begin
        if (|cell_hit) begin
          result_id_next = process_id;
        end else begin
          status_next = swtq_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        status_next    = swtq_pkg::ST_OK;
        result_id_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (accept) begin
      status     <= status_next;
      result_id  <= result_id_next;
      head_valid <= cell_ent_next[0].valid;
      head_time  <= cell_ent_next[0].valid ? cell_ent_next[0].wake : '0;
    end
  end

  // Occupied cells always form a prefix of the row.
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("queue occupancy not contiguous");

  // A dropped insert leaves the row untouched and reports full.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && (op == swtq_pkg::OP_INSERT) && full |=>
      (status == swtq_pkg::ST_FULL) && (valid_vec == $past(valid_vec)))
    else $error("insert into full queue not dropped");

  // Any non-success result carries a zero id.
  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != swtq_pkg::ST_OK) |-> (result_id == '0))
    else $error("nonzero id on failed operation");

  // Head time reads zero whenever the queue is empty.
  a_head_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !head_valid |-> (head_time == '0))
    else $error("head time nonzero on empty queue");

  generate
    for (k = 1; k < QUEUE_DEPTH; k++) begin : g_sorted
      a_sorted: assert property (@(posedge clk) disable iff (rst)
        cell_ent[k].valid |-> (cell_ent[k-1].wake <= cell_ent[k].wake))
        else $error("queue out of order");
    end
  endgenerate

endmodule

FILE: tb/sv/swtq_checker.sv
// Checker for the sorted wake-up timer queue: tracks the queue, predicts each result beat.
`timescale 1ns / 100ps

module swtq_checker #(
  parameter int DEPTH = swtq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic [swtq_pkg::ID_W-1:0]   process_id,
  input  logic [swtq_pkg::TIME_W-1:0] wake_time,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [1:0]                  status,
  input  logic [swtq_pkg::ID_W-1:0]   result_id,
  input  logic                        head_valid,
  input  logic [swtq_pkg::TIME_W-1:0] head_time,
  output int                          mismatches,
  output int                          pending
);

  typedef struct packed {
    swtq_pkg::status_t           status;
    logic [swtq_pkg::ID_W-1:0]   id;
    logic                        head_valid;
    logic [swtq_pkg::TIME_W-1:0] head_time;
  } reply_t;

  // sleeping processes, earliest wake time first
  logic [swtq_pkg::TIME_W-1:0] sleeper_time [DEPTH];
  logic [swtq_pkg::ID_W-1:0]   sleeper_id   [DEPTH];
  int                          sleeper_count;

  reply_t                      predicted_replies [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    sleeper_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t swtq_checker: %s", $time, msg);
    mismatches++;
  endtask

  function automatic reply_t predict_queue_op(swtq_pkg::op_t op,
                                              logic [swtq_pkg::ID_W-1:0] pid,
                                              logic [swtq_pkg::TIME_W-1:0] t);
    reply_t r;
    int     pos;
    int     k;
    bit     hit;
    r = '0;
    r.status = swtq_pkg::ST_OK;
    hit = 1'b0;
    case (op)
      swtq_pkg::OP_INSERT: begin
        if (sleeper_count >= DEPTH) begin
          r.status = swtq_pkg::ST_FULL;
        end else begin
          // equal times stay behind older entries
          pos = 0;
          while (pos < sleeper_count && sleeper_time[pos] <= t) pos++;
          for (k = sleeper_count; k > pos; k--) begin
            sleeper_time[k] = sleeper_time[k-1];
            sleeper_id[k]   = sleeper_id[k-1];
          end
          sleeper_time[pos] = t;
          sleeper_id[pos]   = pid;
          sleeper_count++;
        end
      end
      swtq_pkg::OP_POP: begin
        if (sleeper_count == 0) begin
          r.status = swtq_pkg::ST_EMPTY;
        end else begin
          r.id = sleeper_id[0];
          for (k = 1; k < sleeper_count; k++) begin
            sleeper_time[k-1] = sleeper_time[k];
            sleeper_id[k-1]   = sleeper_id[k];
          end
          sleeper_count--;
        end
      end
      swtq_pkg::OP_LOOKUP: begin
        r.status = swtq_pkg::ST_NOT_FOUND;
        for (k = 0; k < sleeper_count; k++) begin
          if (!hit && sleeper_id[k] == pid) begin
            hit = 1'b1;
            r.status = swtq_pkg::ST_OK;
            r.id = pid;
          end
        end
      end
      default: ;
    endcase
    r.head_valid = (sleeper_count > 0);
    r.head_time  = (sleeper_count > 0) ? sleeper_time[0] : '0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      sleeper_count = 0;
      predicted_replies.delete();
    end else begin
      // result beat first: it belongs to an earlier input beat
      if (out_valid && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected (status %0d id %0h)",
                                    status, result_id));
        end else begin
          want = predicted_replies.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status, want.status));
          if (result_id !== want.id)
            report_mismatch($sformatf("result_id got %0h want %0h", result_id, want.id));
          if (head_valid !== want.head_valid)
            report_mismatch($sformatf("head_valid got %0b want %0b",
                                      head_valid, want.head_valid));
          if (head_time !== want.head_time)
            report_mismatch($sformatf("head_time got %0h want %0h",
                                      head_time, want.head_time));
        end
      end
      if (in_valid && !in_stall)
        predicted_replies.push_back(
          predict_queue_op(swtq_pkg::op_t'(opcode), process_id, wake_time));
    end
    pending <= predicted_replies.size();
  end

endmodule

FILE: tb/sv/tb_sorted_wakeup_timer_queue.sv
// Testbench top for the sorted wake-up timer queue: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_sorted_wakeup_timer_queue;

  localparam int DEPTH = swtq_pkg::DEPTH_DEFAULT;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  opcode;
  logic [swtq_pkg::ID_W-1:0]   process_id;
  logic [swtq_pkg::TIME_W-1:0] wake_time;
  logic                        out_valid;
  logic                        out_stall;
  logic [1:0]                  status;
  logic [swtq_pkg::ID_W-1:0]   result_id;
  logic                        head_valid;
  logic [swtq_pkg::TIME_W-1:0] head_time;

  int                mismatches;
  int                pending;
  int                idle_pct;
  int                stall_pct;

  sorted_wakeup_timer_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .process_id(process_id), .wake_time(wake_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_id(result_id),
    .head_valid(head_valid), .head_time(head_time)
  );

  swtq_checker #(.DEPTH(DEPTH)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .process_id(process_id), .wake_time(wake_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_id(result_id),
    .head_valid(head_valid), .head_time(head_time),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  initial begin
    #2_000_000;
    $display("tb_sorted_wakeup_timer_queue: FAIL");
    $finish;
  end

  // one input beat, preceded by random idle cycles carrying junk payload
  task automatic drive_beat(swtq_pkg::op_t op, logic [swtq_pkg::ID_W-1:0] pid,
                            logic [swtq_pkg::TIME_W-1:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid   <= 1'b0;
      opcode     <= 2'($urandom_range(3));
      process_id <= 8'($urandom_range(255));
      wake_time  <= $urandom;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    process_id <= pid;
    wake_time  <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int                          idle_sel  [4];
    int                          stall_sel [4];
    int                          mode;
    int                          pick;
    bit                          quiet;
    swtq_pkg::op_t               op;
    logic [swtq_pkg::ID_W-1:0]   pid;
    logic [swtq_pkg::TIME_W-1:0] t;

    idle_sel  = '{0, 48, 0, 9};
    stall_sel = '{0, 0, 48, 9};
    rst        = 1'b1;
    in_valid   = 1'b0;
    out_stall  = 1'b0;
    opcode     = '0;
    process_id = '0;
    wake_time  = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    mode       = 0;
    quiet      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty queue, extremes, ties, lookups, fill to full, drop
    drive_beat(swtq_pkg::OP_POP, 8'h00, 32'h0);
    drive_beat(swtq_pkg::OP_LOOKUP, 8'h42, 32'h0);
    drive_beat(swtq_pkg::OP_NOP, 8'hFF, 32'hFFFF_FFFF);
    drive_beat(swtq_pkg::OP_INSERT, 8'hFF, 32'hFFFF_FFFF);
    drive_beat(swtq_pkg::OP_INSERT, 8'h00, 32'h0);
    drive_beat(swtq_pkg::OP_INSERT, 8'h01, 32'd5);
    drive_beat(swtq_pkg::OP_INSERT, 8'h02, 32'd5);
    drive_beat(swtq_pkg::OP_LOOKUP, 8'h02, 32'h0);
    drive_beat(swtq_pkg::OP_LOOKUP, 8'h77, 32'h0);
    drive_beat(swtq_pkg::OP_INSERT, 8'h02, 32'd3);
    drive_beat(swtq_pkg::OP_LOOKUP, 8'h02, 32'h0);
    for (int k = 0; k < 11; k++)
      drive_beat(swtq_pkg::OP_INSERT, 8'(8'hA0 + k), 32'(32'd1000 - 7 * k));
    drive_beat(swtq_pkg::OP_INSERT, 8'h55, 32'd1);
    drive_beat(swtq_pkg::OP_POP, 8'h00, 32'h0);
    drive_beat(swtq_pkg::OP_POP, 8'h00, 32'h0);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < 482; n++) begin
        if (n % 40 == 0) begin
          // 0 fills, 1 drains, 2 mixes; some bursts run without idling
          mode  = $urandom_range(2);
          quiet = ($urandom_range(3) == 0);
          idle_pct  = quiet ? 0 : idle_sel[phase];
          stall_pct = quiet ? 0 : stall_sel[phase];
        end
        pick = $urandom_range(99);
        case (mode)
          0:       op = (pick < 60) ? swtq_pkg::OP_INSERT :
                        (pick < 75) ? swtq_pkg::OP_POP :
                        (pick < 95) ? swtq_pkg::OP_LOOKUP : swtq_pkg::OP_NOP;
          1:       op = (pick < 25) ? swtq_pkg::OP_INSERT :
                        (pick < 70) ? swtq_pkg::OP_POP :
                        (pick < 95) ? swtq_pkg::OP_LOOKUP : swtq_pkg::OP_NOP;
          default: op = (pick < 40) ? swtq_pkg::OP_INSERT :
                        (pick < 70) ? swtq_pkg::OP_POP :
                        (pick < 95) ? swtq_pkg::OP_LOOKUP : swtq_pkg::OP_NOP;
        endcase
        // narrow ids give duplicates and lookup hits
        pid = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
        case ($urandom_range(3))
          0:       t = $urandom_range(31);
          1:       t = $urandom;
          2:       t = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3)
                                         : $urandom_range(3);
          default: t = $urandom_range(1000);
        endcase
        drive_beat(op, pid, t);
      end
      // hold off until every result of this phase has come back
      drain_results();
    end

    stall_pct = 0;
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_sorted_wakeup_timer_queue: PASS");
    end else begin
      $display("tb_sorted_wakeup_timer_queue: FAIL");
    end
    $finish;
  end

endmodule

FILE: sorted_wakeup_timer_queue.f
design/swtq_pkg.sv
design/swtq_cell.sv
design/sorted_wakeup_timer_queue.sv
tb/sv/swtq_checker.sv
tb/sv/tb_sorted_wakeup_timer_queue.sv
